FILE: rtl/core/rsa_pkg.sv
`timescale 1ns / 1ps

package rsa_pkg;

	localparam int SLOTS  = 512;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int JOB_W  = 32;
	localparam int RID_W  = 12;
	localparam int GID_W  = 10;
	localparam int STAT_W = 2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [1:0] {
		MODE_RESERVE = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_CONFIRM = 2'd2
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK
	} state_t;

	// one access to the slot table per cycle
	typedef struct packed {
		logic             we;
		logic             re;
		logic [IDX_W-1:0] addr;
		logic [JOB_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		logic [GID_W-1:0] gid;
		status_t          status;
	} result_t;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
	endfunction

	function automatic logic [GID_W-1:0] grant_of(input logic [IDX_W-1:0] idx);
		logic [31:0] t;
		t = 32'(idx) + 32'd1;
		return t[GID_W-1:0];
	endfunction

	function automatic logic id_ok(input logic [RID_W-1:0] rid);
		return (rid != '0) && (32'(rid) <= 32'(SLOTS));
	endfunction

endpackage

FILE: rtl/core/rsa_ram.sv
`timescale 1ns / 1ps

module rsa_ram (
	input  logic                     clk,
	input  rsa_pkg::mem_req_t        req,
	output logic [rsa_pkg::JOB_W-1:0] rdata
);

	logic [rsa_pkg::JOB_W-1:0] mem [rsa_pkg::SLOTS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
	end

	// hold the last read word while no read is issued
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

FILE: rtl/core/rsa_ctrl.sv
`timescale 1ns / 1ps

module rsa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                mode,
	input  logic [rsa_pkg::JOB_W-1:0] job_number,
	input  logic [rsa_pkg::RID_W-1:0] reservation_id,
	input  logic                      out_free,
	input  logic [rsa_pkg::JOB_W-1:0] rdata,
	output logic                      idle,
	output rsa_pkg::mem_req_t         req,
	output rsa_pkg::result_t          res
);

	rsa_pkg::state_t           state_q, state_d;
	logic [rsa_pkg::IDX_W-1:0] clr_q;
	logic [rsa_pkg::IDX_W-1:0] probe_q;
	logic [rsa_pkg::IDX_W-1:0] cnt_q;
	logic [rsa_pkg::IDX_W-1:0] next_slot_q;
	logic [rsa_pkg::JOB_W-1:0] job_q;
	logic [rsa_pkg::IDX_W-1:0] probe_nxt;
	logic [rsa_pkg::RID_W-1:0] rid_m1;
	logic                      hit;
	logic                      last;

	assign probe_nxt = rsa_pkg::wrap_inc(probe_q);
	assign rid_m1    = reservation_id - rsa_pkg::RID_W'(1);
	assign hit       = (rdata == '0);
	assign last      = (cnt_q == rsa_pkg::LAST_IDX);
	assign idle      = (state_q == rsa_pkg::S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsa_pkg::S_CLEAR: begin
				if (clr_q == rsa_pkg::LAST_IDX) state_d = rsa_pkg::S_IDLE;
			end
			rsa_pkg::S_IDLE: begin
				if (accept && mode == rsa_pkg::MODE_RESERVE) state_d = rsa_pkg::S_CHECK;
			end
			rsa_pkg::S_CHECK: begin
				if (out_free && (hit || last)) state_d = rsa_pkg::S_IDLE;
			end
			default: state_d = rsa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req        = '0;
		res        = '0;
		res.status = rsa_pkg::ST_OK;
		unique case (state_q)
			rsa_pkg::S_CLEAR: begin
				req.we   = 1'b1;
				req.addr = clr_q;
			end
			rsa_pkg::S_IDLE: begin
				if (accept) begin
					unique case (mode)
						rsa_pkg::MODE_RESERVE: begin
							req.re   = 1'b1;
							req.addr = next_slot_q;
						end
						rsa_pkg::MODE_RELEASE: begin
							res.valid = 1'b1;
							if (rsa_pkg::id_ok(reservation_id)) begin
								req.we   = 1'b1;
								req.addr = rid_m1[rsa_pkg::IDX_W-1:0];
							end else begin
								res.status = rsa_pkg::ST_BAD;
							end
						end
						rsa_pkg::MODE_CONFIRM: begin
							res.valid = 1'b1;
							if (job_number == '0 || !rsa_pkg::id_ok(reservation_id)) begin
								res.status = rsa_pkg::ST_BAD;
							end
						end
						default: begin
							res.valid  = 1'b1;
							res.status = rsa_pkg::ST_BAD;
						end
					endcase
				end
			end
			rsa_pkg::S_CHECK: begin
				if (!out_free) begin
					// reread the same slot so the word is still there next cycle
					req.re   = 1'b1;
					req.addr = probe_q;
				end else if (hit) begin
					req.we    = 1'b1;
					req.addr  = probe_q;
					req.wdata = job_q;
					res.valid = 1'b1;
					res.gid   = rsa_pkg::grant_of(probe_q);
				end else if (last) begin
					res.valid  = 1'b1;
					res.status = rsa_pkg::ST_FULL;
				end else begin
					req.re   = 1'b1;
					req.addr = probe_nxt;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rsa_pkg::S_CLEAR;
			clr_q       <= '0;
			next_slot_q <= '0;
			probe_q     <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == rsa_pkg::S_CLEAR) clr_q <= clr_q + rsa_pkg::IDX_W'(1);
			if (state_q == rsa_pkg::S_IDLE && accept && mode == rsa_pkg::MODE_RESERVE) begin
				probe_q <= next_slot_q;
				cnt_q   <= '0;
			end
			if (state_q == rsa_pkg::S_CHECK && out_free) begin
				if (hit) begin
					next_slot_q <= probe_nxt;
				end else if (!last) begin
					probe_q <= probe_nxt;
					cnt_q   <= cnt_q + rsa_pkg::IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rsa_pkg::S_IDLE && accept) job_q <= job_number;
	end

endmodule

FILE: rtl/core/reservation_slot_allocator_top.sv
`timescale 1ns / 1ps

// Next-fit reservation slot allocator.
// Input items arrive on the s_ group: s_tuser carries the mode (reserve,
// release, confirm), s_tdata the job number and the one-based slot number.
// Every item gives exactly one result item on the m_ group: m_tdata the
// granted slot (0 unless a reserve succeeds), m_tuser the status.
// Release and confirm: the result is registered at the accepting edge and
// can be taken in the cycle after; with the receiver ready, one item per cycle.
// Reserve: the slot table is read one slot per cycle, through its single
// read port, starting at the rotating pointer; the first free slot found is
// written with the job and its result registered, and a search that probes
// every slot without a hit registers a full status.
// Only one item is in flight; s_tready returns the cycle after the result
// is registered, provided the output register is empty or being taken.
// Reset: the pointer clears and a clearing pass then writes zero into every
// slot, during which s_tready stays low.
// Receiver stall: the result holds in the output register and s_tready stays
// low until it is taken; a search always starts with that register free.
module reservation_slot_allocator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [31:0] job_number, [43:32] reservation_id, rest zero
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [9:0] granted_id, rest zero
	output logic [1:0]  m_tuser   // [1:0] status
);

	logic                      accept;
	logic                      out_free;
	logic                      idle;
	rsa_pkg::mem_req_t         req;
	rsa_pkg::result_t          res;
	logic [rsa_pkg::JOB_W-1:0] rdata;
	logic [rsa_pkg::GID_W-1:0] gid_q;
	logic [1:0]                status_q;
	logic                      m_tvalid_q;

	// output register is free when empty or being drained this cycle
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = idle && out_free;
	assign accept   = s_tvalid && s_tready;

	rsa_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.mode           (s_tuser),
		.job_number     (s_tdata[31:0]),
		.reservation_id (s_tdata[43:32]),
		.out_free       (out_free),
		.rdata          (rdata),
		.idle           (idle),
		.req            (req),
		.res            (res)
	);

	rsa_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	// valid: load on a new result, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			gid_q    <= res.gid;
			status_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(16 - rsa_pkg::GID_W){1'b0}}, gid_q};
	assign m_tuser  = status_q;

endmodule

FILE: sim/reservation_slot_allocator_top_test.sv
`timescale 1ns / 1ps

module reservation_slot_allocator_top_test;

	// mode 3 has no operation behind it; the block answers it as bad
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int         HOLDOFF_CYCLES = 400;

	typedef struct packed {
		logic [1:0]                mode;
		logic [rsa_pkg::JOB_W-1:0] job;
		logic [rsa_pkg::RID_W-1:0] rid;
	} slot_request_t;

	typedef struct packed {
		logic [rsa_pkg::GID_W-1:0] gid;
		rsa_pkg::status_t          status;
	} slot_outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // [31:0] job_number, [43:32] reservation_id, rest zero
	logic [1:0]  s_tuser = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [9:0] granted_id, rest zero
	logic [1:0]  m_tuser;        // [1:0] status

	reservation_slot_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	slot_request_t             pending_requests[$];
	slot_outcome_t             predicted_outcomes[$];
	logic [rsa_pkg::JOB_W-1:0] slot_job_copy[rsa_pkg::SLOTS];
	logic [rsa_pkg::IDX_W-1:0] search_from;
	int                        item_total;
	int                        accepted_count;
	int                        mismatch_count;
	int                        holdoff_left;
	bit                        holdoff_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// A watchdog only; this fires on a hang, not on a late result.
	initial begin
		#12_000_000;
		$display("reservation_slot_allocator_top verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// Track the slot table and search pointer; return what the block must answer.
	task automatic predict_slot_outcome(input slot_request_t req, output slot_outcome_t res);
		logic [rsa_pkg::IDX_W-1:0] probe;
		logic [rsa_pkg::RID_W-1:0] rid_m1;
		bit                        found;
		res.gid    = '0;
		res.status = rsa_pkg::ST_BAD;
		rid_m1     = req.rid - rsa_pkg::RID_W'(1);
		case (req.mode)
			rsa_pkg::MODE_RESERVE: begin
				res.status = rsa_pkg::ST_FULL;
				probe = search_from;
				found = 1'b0;
				for (int k = 0; k < rsa_pkg::SLOTS && !found; k++) begin
					if (slot_job_copy[probe] == '0) begin
						// a zero job is stored as well, so the slot stays free
						slot_job_copy[probe] = req.job;
						res.gid    = rsa_pkg::GID_W'(probe) + rsa_pkg::GID_W'(1);
						res.status = rsa_pkg::ST_OK;
						search_from = (probe == rsa_pkg::LAST_IDX) ? '0 : probe + 1'b1;
						found = 1'b1;
					end else begin
						probe = (probe == rsa_pkg::LAST_IDX) ? '0 : probe + 1'b1;
					end
				end
			end
			rsa_pkg::MODE_RELEASE: begin
				if (req.rid != '0 && 32'(req.rid) <= rsa_pkg::SLOTS) begin
					slot_job_copy[rid_m1[rsa_pkg::IDX_W-1:0]] = '0;
					res.status = rsa_pkg::ST_OK;
				end
			end
			rsa_pkg::MODE_CONFIRM: begin
				if (req.job != '0 && req.rid != '0 && 32'(req.rid) <= rsa_pkg::SLOTS)
					res.status = rsa_pkg::ST_OK;
			end
			default: ;
		endcase
	endtask

	function automatic bit idle_roll(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	// Sender idles most in the second third, receiver in the first, neither at the end.
	function automatic int sender_idle_pct();
		if (accepted_count < item_total / 3)
			return 38;
		if (accepted_count < 2 * item_total / 3)
			return 55;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (accepted_count < item_total / 3)
			return 55;
		if (accepted_count < 2 * item_total / 3)
			return 38;
		return 0;
	endfunction

	task automatic queue_request(input logic [1:0] mode,
			input logic [rsa_pkg::JOB_W-1:0] job, input logic [rsa_pkg::RID_W-1:0] rid);
		slot_request_t req;
		req.mode = mode;
		req.job  = job;
		req.rid  = rid;
		pending_requests.push_back(req);
	endtask

	function automatic logic [rsa_pkg::JOB_W-1:0] live_job();
		logic [rsa_pkg::JOB_W-1:0] j;
		j = $urandom();
		return (j == '0) ? rsa_pkg::JOB_W'(1) : j;
	endfunction

	function automatic logic [rsa_pkg::RID_W-1:0] outside_rid();
		return ($urandom_range(3, 0) == 0) ? '0 :
			rsa_pkg::RID_W'($urandom_range(4095, rsa_pkg::SLOTS + 1));
	endfunction

	// Driver: advance past an accepted item, hold an unaccepted one, else offer or idle.
	always @(negedge clk) begin : drive_requests
		bit            just_taken;
		slot_request_t head;
		just_taken = 1'b0;
		if (arst_n) begin
			if (accepted_count > item_total - pending_requests.size()) begin
				void'(pending_requests.pop_front());
				just_taken = 1'b1;
			end
			if (s_tvalid && !just_taken) begin
				// hold the current item until the block takes it
			end else if (pending_requests.size() > 0 && !idle_roll(sender_idle_pct())) begin
				head = pending_requests[0];
				s_tvalid <= 1'b1;
				s_tdata  <= {4'b0, head.rid, head.job};
				s_tuser  <= head.mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs the block up
	// while the sender keeps offering.
	always @(negedge clk) begin : drive_result_ready
		if (arst_n) begin
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else if (!holdoff_done && accepted_count >= 3 * item_total / 5) begin
				holdoff_done = 1'b1;
				holdoff_left = HOLDOFF_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !idle_roll(receiver_idle_pct());
			end
		end
	end

	// Monitor: check a result against the oldest prediction first, then record
	// a newly accepted item, so an unexpected result is never masked.
	always @(posedge clk) begin : watch_results
		slot_request_t req;
		slot_outcome_t want;
		slot_outcome_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (predicted_outcomes.size() == 0) begin
					flag_mismatch($sformatf("result gid %0d status %0d with nothing expected",
						m_tdata[rsa_pkg::GID_W-1:0], m_tuser));
				end else begin
					want = predicted_outcomes.pop_front();
					if (m_tdata[rsa_pkg::GID_W-1:0] !== want.gid)
						flag_mismatch($sformatf("granted_id %0d, expected %0d",
							m_tdata[rsa_pkg::GID_W-1:0], want.gid));
					if (m_tuser !== want.status)
						flag_mismatch($sformatf("status %0d, expected %0d",
							m_tuser, want.status));
				end
			end
			if (s_tvalid && s_tready) begin
				req.mode = s_tuser;
				req.job  = s_tdata[31:0];
				req.rid  = s_tdata[43:32];
				predict_slot_outcome(req, got);
				predicted_outcomes.push_back(got);
				accepted_count++;
			end
		end
	end

	initial begin
		int pick;
		for (int k = 0; k < rsa_pkg::SLOTS; k++)
			slot_job_copy[k] = '0;
		search_from    = '0;
		accepted_count = 0;
		mismatch_count = 0;
		holdoff_left   = 0;
		holdoff_done   = 1'b0;
		arst_n         = 1'b0;

		// Directed: field extremes, zero job on reserve, every bad-id and bad-job
		// case, release of a free slot, the unused mode.
		queue_request(rsa_pkg::MODE_RESERVE, 32'hFFFF_FFFF, '0);
		queue_request(rsa_pkg::MODE_RESERVE, 32'h0, 12'hFFF);
		queue_request(rsa_pkg::MODE_RESERVE, 32'h1, 12'd1);
		queue_request(rsa_pkg::MODE_CONFIRM, 32'h0, 12'd1);
		queue_request(rsa_pkg::MODE_CONFIRM, 32'hFFFF_FFFF, 12'd0);
		queue_request(rsa_pkg::MODE_CONFIRM, 32'h5, rsa_pkg::RID_W'(rsa_pkg::SLOTS));
		queue_request(rsa_pkg::MODE_CONFIRM, 32'h5, rsa_pkg::RID_W'(rsa_pkg::SLOTS + 1));
		queue_request(rsa_pkg::MODE_CONFIRM, 32'h5, 12'hFFF);
		queue_request(rsa_pkg::MODE_CONFIRM, 32'h7, 12'd1);
		queue_request(rsa_pkg::MODE_RELEASE, 32'hFFFF_FFFF, 12'd0);
		queue_request(rsa_pkg::MODE_RELEASE, 32'h0, rsa_pkg::RID_W'(rsa_pkg::SLOTS + 1));
		queue_request(rsa_pkg::MODE_RELEASE, 32'h0, 12'hFFF);
		queue_request(rsa_pkg::MODE_RELEASE, 32'h0, rsa_pkg::RID_W'(rsa_pkg::SLOTS));
		queue_request(rsa_pkg::MODE_RELEASE, 32'h0, 12'd1);
		queue_request(rsa_pkg::MODE_RELEASE, 32'h0, 12'd1);
		queue_request(MODE_UNUSED, $urandom(), rsa_pkg::RID_W'($urandom()));
		queue_request(MODE_UNUSED, 32'hFFFF_FFFF, 12'hFFF);
		queue_request(rsa_pkg::MODE_RESERVE, 32'hA5A5_5A5A, 12'h555);
		queue_request(rsa_pkg::MODE_RESERVE, 32'h8000_0000, 12'hAAA);

		// Fill: reserves run the pointer round the table, through the wrap and
		// towards a full table.
		for (int k = 0; k < 520; k++)
			queue_request(rsa_pkg::MODE_RESERVE,
				($urandom_range(49, 0) == 0) ? '0 : live_job(),
				rsa_pkg::RID_W'($urandom()));

		// Churn: releases open holes at random, reserves search for them.
		for (int k = 0; k < 410; k++) begin
			pick = $urandom_range(99, 0);
			if (pick < 40)
				queue_request(rsa_pkg::MODE_RESERVE,
					($urandom_range(29, 0) == 0) ? '0 : live_job(),
					rsa_pkg::RID_W'($urandom()));
			else if (pick < 75)
				queue_request(rsa_pkg::MODE_RELEASE, $urandom(),
					($urandom_range(9, 0) == 0) ? outside_rid() :
					rsa_pkg::RID_W'($urandom_range(rsa_pkg::SLOTS, 1)));
			else if (pick < 92)
				queue_request(rsa_pkg::MODE_CONFIRM,
					($urandom_range(9, 0) == 0) ? '0 : live_job(),
					($urandom_range(3, 0) == 0) ? outside_rid() :
					rsa_pkg::RID_W'($urandom_range(rsa_pkg::SLOTS, 1)));
			else
				queue_request(MODE_UNUSED, $urandom(), rsa_pkg::RID_W'($urandom()));
		end
		item_total = pending_requests.size();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait out every item, then keep watching for stray results
		while (accepted_count < item_total || predicted_outcomes.size() != 0)
			@(posedge clk);
		repeat (rsa_pkg::SLOTS + 20) @(posedge clk);

		if (mismatch_count == 0 && predicted_outcomes.size() == 0)
			$display("reservation_slot_allocator_top verification clean");
		else
			$display("reservation_slot_allocator_top verification failed");
		$finish;
	end

endmodule
